// File: hw/rtl/sct_pkg.sv
package sct_pkg;

    // Default width of the countdown and overtime counters.
    localparam int COUNT_BITS_DEF = 17;

    // Fixed field widths of the streams.
    localparam int OP_W   = 3;
    localparam int LOAD_W = 17;
    localparam int MIN_W  = 12;
    localparam int SEC_W  = 6;

    // Saturation point of the minutes field and the seconds shown with it.
    localparam logic [MIN_W-1:0] MIN_FIELD_MAX = 12'd4095;
    localparam logic [SEC_W-1:0] SEC_FIELD_MAX = 6'd59;

    // Command codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_LOAD   = 3'd2,
        OP_STOP   = 3'd3,
        OP_PAUSE  = 3'd4,
        OP_RESUME = 3'd5,
        OP_FREE   = 3'd6
    } opcode_t;

    // Run status of the session.
    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_ACTIVE  = 2'd1,
        ST_PAUSED  = 2'd2,
        ST_FREE    = 2'd3
    } status_t;

    // What the display shows.
    typedef enum logic [2:0] {
        DISP_STOPPED = 3'd0,
        DISP_FREE    = 3'd1,
        DISP_WAIT    = 3'd2,
        DISP_TIME    = 3'd3,
        DISP_PAUSED  = 3'd4
    } disp_t;

    // Status fields that travel alongside the shown count.
    typedef struct packed {
        status_t status;
        logic    down;
        logic    relay;
        disp_t   mode;
    } view_t;

endpackage

// File: hw/rtl/sct_state.sv
module sct_state #(
    parameter int COUNT_BITS = sct_pkg::COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sct_pkg::opcode_t            in_opcode,
    input  logic [sct_pkg::LOAD_W-1:0]  in_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sct_pkg::view_t              out_view,
    output logic [COUNT_BITS-1:0]       out_shown
);

    sct_pkg::status_t        status_reg, status_next;
    logic [COUNT_BITS-1:0]   left_reg, left_next;
    logic [COUNT_BITS-1:0]   over_reg, over_next;
    logic                    down_reg, down_next;
    logic                    relay_reg, relay_next;

    logic                    snap_valid_reg;
    sct_pkg::view_t          snap_view_reg, snap_view_next;
    logic [COUNT_BITS-1:0]   snap_shown_reg, snap_shown_next;

    logic                    accept;
    logic                    load_sat;

    // The snapshot stage takes a new transaction when empty or being drained.
    assign in_ready = !snap_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // A load longer than the counter can hold sticks at the counter's maximum.
    assign load_sat = (33'(in_load) > 33'({COUNT_BITS{1'b1}}));

    // Command decode and next session state.
    always_comb begin
        status_next = status_reg;
        left_next   = left_reg;
        over_next   = over_reg;
        down_next   = down_reg;
        relay_next  = relay_reg;
        case (in_opcode)
            sct_pkg::OP_TICK: begin
                if (status_reg == sct_pkg::ST_ACTIVE) begin
                    if (down_reg) begin
                        if (left_reg != '0) begin
                            left_next = left_reg - COUNT_BITS'(1);
                        end else begin
                            down_next = 1'b0;
                            over_next = '0;
                        end
                    end else if (over_reg != {COUNT_BITS{1'b1}}) begin
                        over_next = over_reg + COUNT_BITS'(1);
                    end
                end
            end
            sct_pkg::OP_START: begin
                status_next = sct_pkg::ST_ACTIVE;
                left_next   = '0;
                over_next   = '0;
                down_next   = 1'b1;
                relay_next  = 1'b1;
            end
            sct_pkg::OP_LOAD: begin
                over_next = '0;
                down_next = 1'b1;
                if (in_load == '0) begin
                    left_next = '0;
                end else begin
                    left_next  = load_sat ? {COUNT_BITS{1'b1}} : COUNT_BITS'(in_load);
                    relay_next = 1'b1;
                end
            end
            sct_pkg::OP_STOP: begin
                status_next = sct_pkg::ST_STOPPED;
                left_next   = '0;
                over_next   = '0;
                relay_next  = 1'b0;
            end
            sct_pkg::OP_PAUSE: begin
                if (status_reg == sct_pkg::ST_ACTIVE) begin
                    status_next = sct_pkg::ST_PAUSED;
                end
            end
            sct_pkg::OP_RESUME: begin
                if (status_reg == sct_pkg::ST_PAUSED) begin
                    status_next = sct_pkg::ST_ACTIVE;
                end
            end
            sct_pkg::OP_FREE: begin
                status_next = sct_pkg::ST_FREE;
                left_next   = '0;
                over_next   = '0;
                relay_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Display mode and shown count, taken from the updated state.
    always_comb begin
        snap_view_next.status = status_next;
        snap_view_next.down   = down_next;
        snap_view_next.relay  = relay_next;
        case (status_next)
            sct_pkg::ST_STOPPED: snap_view_next.mode = sct_pkg::DISP_STOPPED;
            sct_pkg::ST_FREE:    snap_view_next.mode = sct_pkg::DISP_FREE;
            sct_pkg::ST_PAUSED:  snap_view_next.mode = sct_pkg::DISP_PAUSED;
            default: begin
                if (down_next && left_next == '0 && over_next == '0) begin
                    snap_view_next.mode = sct_pkg::DISP_WAIT;
                end else begin
                    snap_view_next.mode = sct_pkg::DISP_TIME;
                end
            end
        endcase
        if (snap_view_next.mode inside {sct_pkg::DISP_TIME, sct_pkg::DISP_PAUSED}) begin
            snap_shown_next = down_next ? left_next : over_next;
        end else begin
            snap_shown_next = '0;
        end
    end

    // Session state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= sct_pkg::ST_STOPPED;
            left_reg   <= '0;
            over_reg   <= '0;
            down_reg   <= 1'b1;
            relay_reg  <= 1'b0;
        end else if (accept) begin
            status_reg <= status_next;
            left_reg   <= left_next;
            over_reg   <= over_next;
            down_reg   <= down_next;
            relay_reg  <= relay_next;
        end
    end

    // Snapshot stage handed to the formatter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (in_ready) begin
            snap_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snap_view_reg  <= snap_view_next;
            snap_shown_reg <= snap_shown_next;
        end
    end

    assign out_valid = snap_valid_reg;
    assign out_view  = snap_view_reg;
    assign out_shown = snap_shown_reg;

`ifndef NO_ASSERTIONS
    // Overtime only ever runs after the countdown has ended.
    a_over_only_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (over_reg != '0) |-> !down_reg)
        else $error("overtime counts while counting down");

    // Counting up means the countdown sits at zero.
    a_left_zero_up: assert property (@(posedge aclk) disable iff (!aresetn)
        !down_reg |-> (left_reg == '0))
        else $error("remaining time nonzero in overtime");

    // Modes without time carry a zero count.
    a_shown_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && snap_view_reg.mode != sct_pkg::DISP_TIME
         && snap_view_reg.mode != sct_pkg::DISP_PAUSED) |-> (snap_shown_reg == '0))
        else $error("shown count set in a mode without time");
`endif

endmodule

// File: hw/rtl/sct_format.sv
module sct_format #(
    parameter int COUNT_BITS = sct_pkg::COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sct_pkg::view_t              in_view,
    input  logic [COUNT_BITS-1:0]       in_shown,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sct_pkg::view_t              out_view,
    output logic [sct_pkg::MIN_W-1:0]   out_minutes,
    output logic [sct_pkg::SEC_W-1:0]   out_seconds
);

    // The count is split as 4*y + lo; y/15 comes from a reciprocal product.
    localparam int Y_W   = COUNT_BITS - 2;
    localparam int SHIFT = Y_W + 4;
    localparam int R_W   = Y_W + 1;
    localparam int P_W   = Y_W + R_W;
    localparam int Q_W   = P_W - SHIFT;
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / 15;
    localparam logic [R_W-1:0] RECIP_C = R_W'(RECIP);

    logic                   mul_valid_reg;
    sct_pkg::view_t         mul_view_reg;
    logic [P_W-1:0]         mul_prod_reg;
    logic [Y_W-1:0]         mul_y_reg;
    logic [1:0]             mul_lo_reg;
    logic                   mul_ready;

    logic                   res_valid_reg;
    sct_pkg::view_t         res_view_reg;
    logic [sct_pkg::MIN_W-1:0] res_min_reg, res_min_next;
    logic [sct_pkg::SEC_W-1:0] res_sec_reg, res_sec_next;
    logic                   res_ready;

    logic [Q_W-1:0]         quot_est;
    logic [Y_W:0]           rem_est;
    logic                   rem_fix;
    logic [Q_W-1:0]         quot;
    logic [3:0]             rem;

    assign res_ready = !res_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || res_ready;
    assign in_ready  = mul_ready;

    // Multiply stage: estimate of y/15, low by at most one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_view_reg <= in_view;
            mul_prod_reg <= P_W'(in_shown[COUNT_BITS-1:2]) * P_W'(RECIP_C);
            mul_y_reg    <= in_shown[COUNT_BITS-1:2];
            mul_lo_reg   <= in_shown[1:0];
        end
    end

    // Correction by one step, then minutes and seconds with saturation.
    always_comb begin
        quot_est = mul_prod_reg[P_W-1:SHIFT];
        rem_est  = (Y_W + 1)'(mul_y_reg)
                 - (((Y_W + 1)'(quot_est) << 4) - (Y_W + 1)'(quot_est));
        rem_fix  = (rem_est >= (Y_W + 1)'(15));
        quot     = quot_est + Q_W'(rem_fix);
        rem      = rem_fix ? 4'(rem_est - (Y_W + 1)'(15)) : 4'(rem_est);
        if (33'(quot) > 33'(sct_pkg::MIN_FIELD_MAX)) begin
            res_min_next = sct_pkg::MIN_FIELD_MAX;
            res_sec_next = sct_pkg::SEC_FIELD_MAX;
        end else begin
            res_min_next = sct_pkg::MIN_W'(quot);
            res_sec_next = {rem, mul_lo_reg};
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && mul_valid_reg) begin
            res_view_reg <= mul_view_reg;
            res_min_reg  <= res_min_next;
            res_sec_reg  <= res_sec_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_view    = res_view_reg;
    assign out_minutes = res_min_reg;
    assign out_seconds = res_sec_reg;

`ifndef NO_ASSERTIONS
    // The corrected remainder always lands below one minute.
    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (res_sec_reg <= sct_pkg::SEC_FIELD_MAX))
        else $error("seconds field out of range");

    // The reciprocal estimate is never off by more than one.
    a_est_close: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg |-> (rem_est < (Y_W + 1)'(30)))
        else $error("quotient estimate off by more than one");

    // A transaction taken in is held in the multiply stage next cycle.
    a_stage_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> mul_valid_reg)
        else $error("accepted transaction lost in multiply stage");
`endif

endmodule

// File: hw/rtl/session_countdown_overtime_timer_core.sv
// Channel  Dir  Ports             Contents
// s_       in   tvalid/tready     tuser: opcode; tdata: load_value
// m_       out  tvalid/tready     tdata: status, flags, display mode, minutes, seconds
//
// One transaction is accepted per cycle while s_tready is high; it passes the snapshot,
// multiply and result registers in that order before m_tvalid rises.
// The stages are the state update, the reciprocal multiply and the result register.
// Reset (aresetn low at a clock edge) stops the session and empties the pipeline.
// A stalled m_ side fills the stages before s_tready drops.
module session_countdown_overtime_timer_core #(
    parameter int COUNT_BITS = sct_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] load_value, [23:17] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] run_state, [2] counting_down, [3] relay_on,
                                   // [6:4] display_mode, [18:7] shown_minutes,
                                   // [24:19] shown_seconds, [31:25] zero
);

    logic                       snap_valid;
    logic                       snap_ready;
    sct_pkg::view_t             snap_view;
    logic [COUNT_BITS-1:0]      snap_shown;
    sct_pkg::view_t             res_view;
    logic [sct_pkg::MIN_W-1:0]  res_minutes;
    logic [sct_pkg::SEC_W-1:0]  res_seconds;

    sct_state #(
        .COUNT_BITS (COUNT_BITS)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (sct_pkg::opcode_t'(s_tuser)),
        .in_load   (s_tdata[sct_pkg::LOAD_W-1:0]),
        .out_valid (snap_valid),
        .out_ready (snap_ready),
        .out_view  (snap_view),
        .out_shown (snap_shown)
    );

    sct_format #(
        .COUNT_BITS (COUNT_BITS)
    ) u_format (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (snap_valid),
        .in_ready    (snap_ready),
        .in_view     (snap_view),
        .in_shown    (snap_shown),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_view    (res_view),
        .out_minutes (res_minutes),
        .out_seconds (res_seconds)
    );

    // Pack the result fields, highest field first.
    assign m_tdata = {7'b0, res_seconds, res_minutes, res_view.mode,
                      res_view.relay, res_view.down, res_view.status};

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_BITS = sct_pkg::COUNT_BITS_DEF;
    localparam logic [TIMER_BITS-1:0] COUNT_MAX = '1;
    localparam int SECS_PER_MIN = 60;
    // Unused opcode value; the block must leave its state alone.
    localparam logic [sct_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic [sct_pkg::LOAD_W-1:0] LOAD_FULL = '1;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PRINT_LIMIT = 30;

    // Expected readout of one transaction on the result side.
    typedef struct packed {
        sct_pkg::view_t            view;
        logic [sct_pkg::MIN_W-1:0] mins;
        logic [sct_pkg::SEC_W-1:0] secs;
    } readout_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predicted session state.
    sct_pkg::status_t      sess_status;
    logic [TIMER_BITS-1:0] sess_left;
    logic [TIMER_BITS-1:0] sess_over;
    logic                  sess_down;
    logic                  sess_relay;

    readout_t    pending_readouts[$];
    int unsigned commands_sent = 0;
    int unsigned results_checked = 0;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;

    session_countdown_overtime_timer_core #(
        .COUNT_BITS(TIMER_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the predicted state and return what the block should show.
    function automatic readout_t advance_session(input logic [sct_pkg::OP_W-1:0] op,
                                                 input logic [sct_pkg::LOAD_W-1:0] load);
        readout_t              r;
        logic [TIMER_BITS-1:0] shown;
        longint unsigned       mins_full;
        longint unsigned       secs_full;
        case (op)
            sct_pkg::OP_TICK: begin
                if (sess_status == sct_pkg::ST_ACTIVE) begin
                    if (sess_down) begin
                        if (sess_left != 0) begin
                            sess_left = sess_left - 1'b1;
                        end else begin
                            sess_down = 1'b0;
                            sess_over = '0;
                        end
                    end else if (sess_over != COUNT_MAX) begin
                        sess_over = sess_over + 1'b1;
                    end
                end
            end
            sct_pkg::OP_START: begin
                sess_status = sct_pkg::ST_ACTIVE;
                sess_left = '0;
                sess_over = '0;
                sess_down = 1'b1;
                sess_relay = 1'b1;
            end
            sct_pkg::OP_LOAD: begin
                sess_left = '0;
                sess_over = '0;
                sess_down = 1'b1;
                if (load != 0) begin
                    if ((load >> TIMER_BITS) != 0) begin
                        sess_left = COUNT_MAX;
                    end else begin
                        sess_left = TIMER_BITS'(load);
                    end
                    sess_relay = 1'b1;
                end
            end
            sct_pkg::OP_STOP: begin
                sess_status = sct_pkg::ST_STOPPED;
                sess_left = '0;
                sess_over = '0;
                sess_relay = 1'b0;
            end
            sct_pkg::OP_PAUSE: begin
                if (sess_status == sct_pkg::ST_ACTIVE) sess_status = sct_pkg::ST_PAUSED;
            end
            sct_pkg::OP_RESUME: begin
                if (sess_status == sct_pkg::ST_PAUSED) sess_status = sct_pkg::ST_ACTIVE;
            end
            sct_pkg::OP_FREE: begin
                sess_status = sct_pkg::ST_FREE;
                sess_left = '0;
                sess_over = '0;
                sess_relay = 1'b1;
            end
            default: begin
            end
        endcase

        r.view.status = sess_status;
        r.view.down = sess_down;
        r.view.relay = sess_relay;
        if (sess_status == sct_pkg::ST_STOPPED) begin
            r.view.mode = sct_pkg::DISP_STOPPED;
        end else if (sess_status == sct_pkg::ST_FREE) begin
            r.view.mode = sct_pkg::DISP_FREE;
        end else if (sess_status == sct_pkg::ST_PAUSED) begin
            r.view.mode = sct_pkg::DISP_PAUSED;
        end else if (sess_down && sess_left == 0 && sess_over == 0) begin
            r.view.mode = sct_pkg::DISP_WAIT;
        end else begin
            r.view.mode = sct_pkg::DISP_TIME;
        end

        // Only the time and paused modes show a count; it saturates at the minutes field.
        r.mins = '0;
        r.secs = '0;
        if (r.view.mode == sct_pkg::DISP_TIME || r.view.mode == sct_pkg::DISP_PAUSED) begin
            shown = sess_down ? sess_left : sess_over;
            mins_full = longint'(shown) / SECS_PER_MIN;
            secs_full = longint'(shown) % SECS_PER_MIN;
            if (mins_full > sct_pkg::MIN_FIELD_MAX) begin
                r.mins = sct_pkg::MIN_FIELD_MAX;
                r.secs = sct_pkg::SEC_FIELD_MAX;
            end else begin
                r.mins = sct_pkg::MIN_W'(mins_full);
                r.secs = sct_pkg::SEC_W'(secs_full);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
        end
    endtask

    // Drive one command at the falling edge, after a random idle gap, and wait
    // for the transaction to be accepted.
    task automatic send_command(input logic [sct_pkg::OP_W-1:0] op,
                                input logic [sct_pkg::LOAD_W-1:0] load);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, load};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readouts.push_back(advance_session(op, load));
        commands_sent++;
    endtask

    task automatic send_tick();
        send_command(sct_pkg::OP_TICK, sct_pkg::LOAD_W'($urandom));
    endtask

    // Compare every result transaction with the oldest prediction.
    always @(posedge aclk) begin : check_results
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readouts.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%08h", m_tdata));
            end else begin
                want = pending_readouts.pop_front();
                compare_field("run_state", m_tdata[1:0], want.view.status);
                compare_field("counting_down", m_tdata[2], want.view.down);
                compare_field("relay_on", m_tdata[3], want.view.relay);
                compare_field("display_mode", m_tdata[6:4], want.view.mode);
                compare_field("shown_minutes", m_tdata[18:7], want.mins);
                compare_field("shown_seconds", m_tdata[24:19], want.secs);
            end
            results_checked++;
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
                $display("session_countdown_overtime_timer_core verification failed");
                $finish;
            end
        end
    end

    // Corner cases: ignored commands in the stopped, paused and free status, loads at the
    // extremes, waiting and paused display, free run and the unused opcode.
    task automatic test_directed_commands();
        send_command(sct_pkg::OP_TICK, LOAD_FULL);
        send_command(sct_pkg::OP_PAUSE, '0);
        send_command(sct_pkg::OP_RESUME, '0);
        send_command(OP_UNUSED, LOAD_FULL);
        send_command(sct_pkg::OP_LOAD, '0);
        send_command(sct_pkg::OP_LOAD, LOAD_FULL);
        send_command(sct_pkg::OP_START, '0);
        send_command(sct_pkg::OP_TICK, '0);
        send_command(sct_pkg::OP_TICK, '0);
        send_command(sct_pkg::OP_LOAD, 17'd61);
        send_command(sct_pkg::OP_TICK, '0);
        send_command(sct_pkg::OP_PAUSE, '0);
        send_command(sct_pkg::OP_TICK, '0);
        send_command(sct_pkg::OP_PAUSE, '0);
        send_command(OP_UNUSED, '0);
        send_command(sct_pkg::OP_RESUME, '0);
        send_command(sct_pkg::OP_LOAD, LOAD_FULL);
        send_command(sct_pkg::OP_FREE, '0);
        send_command(sct_pkg::OP_TICK, '0);
        send_command(sct_pkg::OP_PAUSE, '0);
        send_command(sct_pkg::OP_RESUME, '0);
        send_command(sct_pkg::OP_LOAD, 17'd5);
        send_command(sct_pkg::OP_STOP, '0);
        send_command(sct_pkg::OP_START, '0);
        send_command(sct_pkg::OP_STOP, '0);
    endtask

    // Mostly well-formed sessions with random lengths, pauses and early stops,
    // mixed with bursts of arbitrary commands.
    task automatic test_random_sessions(input int unsigned n_items);
        int unsigned target;
        int unsigned roll;
        int unsigned length;
        int unsigned n_ticks;
        target = commands_sent + n_items;
        while (commands_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(sct_pkg::OP_W'($urandom_range(7)),
                                 sct_pkg::LOAD_W'($urandom));
                end
            end else if (roll < 22) begin
                send_command(sct_pkg::OP_FREE, sct_pkg::LOAD_W'($urandom));
                repeat ($urandom_range(0, 5)) begin
                    send_command(sct_pkg::OP_W'($urandom_range(sct_pkg::OP_TICK,
                                                               sct_pkg::OP_RESUME)),
                                 sct_pkg::LOAD_W'($urandom_range(0, 300)));
                end
                send_command(sct_pkg::OP_STOP, sct_pkg::LOAD_W'($urandom));
            end else begin
                if ($urandom_range(9) != 0) begin
                    send_command(sct_pkg::OP_START, sct_pkg::LOAD_W'($urandom));
                end
                roll = $urandom_range(99);
                if (roll < 70) begin
                    length = $urandom_range(1, 90);
                    n_ticks = length + $urandom_range(0, 80);
                end else if (roll < 85) begin
                    length = $urandom_range(91, 400);
                    n_ticks = $urandom_range(0, 40);
                end else if (roll < 95) begin
                    length = 0;
                    n_ticks = $urandom_range(0, 90);
                end else begin
                    length = $urandom_range(0, 2 ** sct_pkg::LOAD_W - 1);
                    n_ticks = $urandom_range(0, 10);
                end
                send_command(sct_pkg::OP_LOAD, sct_pkg::LOAD_W'(length));
                for (int unsigned t = 0; t < n_ticks; t++) begin
                    roll = $urandom_range(99);
                    if (roll < 4) begin
                        send_command(sct_pkg::OP_PAUSE, sct_pkg::LOAD_W'($urandom));
                        repeat ($urandom_range(0, 3)) send_tick();
                        if ($urandom_range(3) == 0) send_command(sct_pkg::OP_PAUSE, '0);
                        send_command(sct_pkg::OP_RESUME, sct_pkg::LOAD_W'($urandom));
                    end else if (roll < 5) begin
                        send_command(sct_pkg::OP_LOAD,
                                     sct_pkg::LOAD_W'($urandom_range(0, 120)));
                    end else if (roll < 7) begin
                        break;
                    end else begin
                        send_tick();
                    end
                end
                if ($urandom_range(4) != 0) begin
                    send_command(sct_pkg::OP_STOP, sct_pkg::LOAD_W'($urandom));
                end
            end
        end
    endtask

    // Count a short session down past zero and well into overtime, with a pause.
    task automatic test_overtime_run();
        send_command(sct_pkg::OP_START, '0);
        send_command(sct_pkg::OP_LOAD, 17'd2);
        repeat (40) send_tick();
        send_command(sct_pkg::OP_PAUSE, '0);
        send_tick();
        send_command(sct_pkg::OP_RESUME, '0);
        send_tick();
        send_command(sct_pkg::OP_STOP, '0);
    endtask

    initial begin
        sess_status = sct_pkg::ST_STOPPED;
        sess_left = '0;
        sess_over = '0;
        sess_down = 1'b1;
        sess_relay = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct = 28;
        receiver_idle_pct = 45;
        test_directed_commands();
        test_random_sessions(450);

        sender_idle_pct = 45;
        receiver_idle_pct = 28;
        test_random_sessions(450);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_sessions(430);
        test_overtime_run();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d commands and ticks: directed corner cases, random sessions",
                 commands_sent);
        $display("under three idling mixes, and a long overtime run; %0d results, %0d errors.",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("session_countdown_overtime_timer_core verification clean");
        end else begin
            $display("session_countdown_overtime_timer_core verification failed");
        end
        $finish;
    end

endmodule
